>>> sv/stt_pkg.sv
// Shared types and constants for the slot table with expiry timers.
// No dependencies; imported by every module of the block.
`default_nettype none

package stt_pkg;

   localparam logic [15:0] FREE_OWNER  = 16'hffff;
   localparam int          MAX_RESULTS = 16;
   localparam int          EXP_CNT_W   = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      ACT_ADD       = 2'd0,
      ACT_TICK      = 2'd1,
      ACT_REM_OWNER = 2'd2,
      ACT_REM_SLOT  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EXPIRED   = 3'd3,
      ST_NONE      = 3'd4
   } status_type;

   // one result transaction
   typedef struct packed {
      logic [3:0] slot_number;
      status_type status;
      logic       last_result;
   } rsp_type;

   // memory write controls, shared address
   typedef struct packed {
      logic        owner_we;
      logic        life_we;
      logic [15:0] owner;
      logic [15:0] life;
   } mem_wr_type;

endpackage

`default_nettype wire

>>> sv/slot_table_with_expiry_top.sv
// Remove by slot, or add/remove with the free owner code, goes straight to the result state, then the output register.
// Add and remove by owner walk the slots one per cycle through the memory read port while the output
// register can take a result; the walk runs to the end if the table is full or no slot matches. Tick
// always walks all slots before its last result.
// One transaction at a time; the next is taken once the last result sits in the output register.
// Reset clears the occupancy flags and the sequencer; the slot memory is not cleared.
`default_nettype none

module slot_table_with_expiry_top #(
   parameter int SLOT_COUNT = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [15:0] req_owner_id,
   input  wire  [15:0] req_lifetime,
   input  wire  [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [3:0]  rsp_slot_number,
   output logic [2:0]  rsp_status,
   output logic        rsp_last_result
);
   import stt_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);

   logic              out_ready;
   logic              emit_valid;
   rsp_type           emit_data;
   mem_wr_type        mem_wr;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [15:0]       mem_rd_owner;
   logic [15:0]       mem_rd_life;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff, out_data_in;

   stt_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_owner_id   (req_owner_id),
      .req_lifetime   (req_lifetime),
      .req_slot_index (req_slot_index),
      .out_ready      (out_ready),
      .emit_valid     (emit_valid),
      .emit_data      (emit_data),
      .mem_wr         (mem_wr),
      .mem_wr_addr    (mem_wr_addr),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_owner   (mem_rd_owner),
      .mem_rd_life    (mem_rd_life)
   );

   stt_mem #(.DEPTH(SLOT_COUNT)) u_mem (
      .clock    (clock),
      .wr       (mem_wr),
      .wr_addr  (mem_wr_addr),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_owner (mem_rd_owner),
      .rd_life  (mem_rd_life)
   );

   // output register: free, or draining this cycle
   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign out_valid_in = out_ready ? emit_valid : out_valid_ff;
   assign out_data_in  = (out_ready && emit_valid) ? emit_data : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_slot_number = out_data_ff.slot_number;
   assign rsp_status      = out_data_ff.status;
   assign rsp_last_result = out_data_ff.last_result;

endmodule

`default_nettype wire

>>> sv/stt_mem.sv
// Slot storage: owner and lifetime arrays, one write port, one registered read port.
// Depends on stt_pkg for the write control struct.
`default_nettype none

module stt_mem #(
   parameter int DEPTH = 16
) (
   input  wire                        clock,
   input  stt_pkg::mem_wr_type        wr,
   input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire                        rd_en,
   input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [15:0]                rd_owner,
   output logic [15:0]                rd_life
);
   import stt_pkg::*;

   logic [15:0] owner_mem [DEPTH];
   logic [15:0] life_mem  [DEPTH];
   logic [15:0] rd_owner_ff;
   logic [15:0] rd_life_ff;

   always_ff @(posedge clock) begin
      if (wr.owner_we) begin
         owner_mem[wr_addr] <= wr.owner;
      end
      if (wr.life_we) begin
         life_mem[wr_addr] <= wr.life;
      end
      if (rd_en) begin
         rd_owner_ff <= owner_mem[rd_addr];
         rd_life_ff  <= life_mem[rd_addr];
      end
   end

   assign rd_owner = rd_owner_ff;
   assign rd_life  = rd_life_ff;

endmodule

`default_nettype wire

>>> sv/stt_ctrl.sv
// Sequencer: occupancy flags and the slot walk that reads, updates and writes back memory.
// Depends on stt_pkg; drives stt_mem and the output register in the top level.
`default_nettype none

module stt_ctrl #(
   parameter int SLOT_COUNT = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [1:0]                        req_action,
   input  wire  [15:0]                       req_owner_id,
   input  wire  [15:0]                       req_lifetime,
   input  wire  [3:0]                        req_slot_index,
   input  wire                               out_ready,
   output logic                              emit_valid,
   output stt_pkg::rsp_type                  emit_data,
   output stt_pkg::mem_wr_type               mem_wr,
   output logic [$clog2(SLOT_COUNT)-1:0]     mem_wr_addr,
   output logic                              mem_rd_en,
   output logic [$clog2(SLOT_COUNT)-1:0]     mem_rd_addr,
   input  wire  [15:0]                       mem_rd_owner,
   input  wire  [15:0]                       mem_rd_life
);
   import stt_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = IDX_W + 1;
   localparam int SW    = (IDX_W > 4) ? IDX_W : 4;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_RESULT = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   action_type             act_ff, act_in;
   logic [15:0]            owner_ff, owner_in;
   logic [15:0]            life_ff, life_in;
   logic [SLOT_COUNT-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]       proc_idx_ff, proc_idx_in;
   logic [3:0]             pend_slot_ff, pend_slot_in;
   status_type             pend_status_ff, pend_status_in;
   logic                   have_pend_ff, have_pend_in;
   logic [EXP_CNT_W-1:0]   exp_cnt_ff, exp_cnt_in;

   logic [SW:0]            sidx_ext;
   logic                   sidx_ok;
   logic                   req_fire;

   assign sidx_ext  = (SW+1)'(req_slot_index);
   assign sidx_ok   = sidx_ext < (SW+1)'(SLOT_COUNT);
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      logic        hit;
      logic [15:0] life_dec;
      hit            = 1'b0;
      life_dec       = mem_rd_life - 16'd1;
      state_in       = state_ff;
      act_in         = act_ff;
      owner_in       = owner_ff;
      life_in        = life_ff;
      occ_in         = occ_ff;
      rd_idx_in      = rd_idx_ff;
      proc_valid_in  = proc_valid_ff;
      proc_idx_in    = proc_idx_ff;
      pend_slot_in   = pend_slot_ff;
      pend_status_in = pend_status_ff;
      have_pend_in   = have_pend_ff;
      exp_cnt_in     = exp_cnt_ff;
      emit_valid     = 1'b0;
      emit_data      = '{slot_number: pend_slot_ff, status: pend_status_ff, last_result: 1'b1};
      mem_wr         = '{owner_we: 1'b0, life_we: 1'b0, owner: owner_ff, life: life_ff};
      mem_wr_addr    = proc_idx_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in       = action_type'(req_action);
               owner_in     = req_owner_id;
               life_in      = req_lifetime;
               have_pend_in = 1'b0;
               exp_cnt_in   = '0;
               pend_slot_in = 4'd0;
               priority if (req_action == ACT_REM_SLOT) begin
                  if (sidx_ok && occ_ff[sidx_ext[IDX_W-1:0]]) begin
                     occ_in[sidx_ext[IDX_W-1:0]] = 1'b0;
                     pend_slot_in   = req_slot_index;
                     pend_status_in = ST_DONE;
                  end else begin
                     pend_status_in = ST_NOT_FOUND;
                  end
                  state_in = S_RESULT;
               end else if ((req_action == ACT_ADD || req_action == ACT_REM_OWNER)
                            && req_owner_id == FREE_OWNER) begin
                  pend_status_in = ST_NOT_FOUND;
                  state_in       = S_RESULT;
               end else begin
                  // start the walk: slot 0 read now, checked in S_WALK from the registered read data
                  mem_rd_en     = 1'b1;
                  mem_rd_addr   = '0;
                  proc_valid_in = 1'b1;
                  proc_idx_in   = '0;
                  rd_idx_in     = CNT_W'(1);
                  state_in      = S_WALK;
               end
            end
         end

         S_WALK: begin
            // whole pipeline holds while the output register cannot take a result
            if (out_ready) begin
               if (proc_valid_ff) begin
                  unique case (act_ff)
                     ACT_ADD: begin
                        if (!occ_ff[proc_idx_ff]) begin
                           occ_in[proc_idx_ff] = 1'b1;
                           mem_wr.owner_we     = 1'b1;
                           mem_wr.life_we      = 1'b1;
                           pend_slot_in        = 4'(proc_idx_ff);
                           pend_status_in      = ST_DONE;
                           hit                 = 1'b1;
                        end
                     end
                     ACT_REM_OWNER: begin
                        if (occ_ff[proc_idx_ff] && mem_rd_owner == owner_ff) begin
                           occ_in[proc_idx_ff] = 1'b0;
                           pend_slot_in        = 4'(proc_idx_ff);
                           pend_status_in      = ST_DONE;
                           hit                 = 1'b1;
                        end
                     end
                     ACT_TICK: begin
                        if (occ_ff[proc_idx_ff]) begin
                           mem_wr.life_we = 1'b1;
                           mem_wr.life    = life_dec;
                           if (life_dec == 16'd0) begin
                              occ_in[proc_idx_ff] = 1'b0;
                              // previous expiry goes out once a later one is known
                              if (exp_cnt_ff < EXP_CNT_W'(MAX_RESULTS)) begin
                                 if (have_pend_ff) begin
                                    emit_valid = 1'b1;
                                    emit_data.last_result = 1'b0;
                                 end
                                 pend_slot_in   = 4'(proc_idx_ff);
                                 pend_status_in = ST_EXPIRED;
                                 have_pend_in   = 1'b1;
                                 exp_cnt_in     = exp_cnt_ff + EXP_CNT_W'(1);
                              end
                           end
                        end
                     end
                     ACT_REM_SLOT: begin
                        hit = 1'b0;
                     end
                  endcase
               end

               if (hit) begin
                  proc_valid_in = 1'b0;
                  state_in      = S_RESULT;
               end else if (rd_idx_ff < CNT_W'(SLOT_COUNT)) begin
                  mem_rd_en     = 1'b1;
                  proc_valid_in = 1'b1;
                  proc_idx_in   = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in     = rd_idx_ff + CNT_W'(1);
               end else begin
                  proc_valid_in = 1'b0;
                  if (!proc_valid_ff) begin
                     state_in = S_RESULT;
                     unique case (act_ff)
                        ACT_ADD: begin
                           pend_slot_in   = 4'd0;
                           pend_status_in = ST_FULL;
                        end
                        ACT_TICK: begin
                           if (!have_pend_ff) begin
                              pend_slot_in   = 4'd0;
                              pend_status_in = ST_NONE;
                           end
                        end
                        ACT_REM_OWNER, ACT_REM_SLOT: begin
                           pend_slot_in   = 4'd0;
                           pend_status_in = ST_NOT_FOUND;
                        end
                     endcase
                  end
               end
            end
         end

         S_RESULT: begin
            if (out_ready) begin
               emit_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         proc_valid_ff <= 1'b0;
         have_pend_ff  <= 1'b0;
         exp_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         proc_valid_ff <= proc_valid_in;
         have_pend_ff  <= have_pend_in;
         exp_cnt_ff    <= exp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      owner_ff       <= owner_in;
      life_ff        <= life_in;
      rd_idx_ff      <= rd_idx_in;
      proc_idx_ff    <= proc_idx_in;
      pend_slot_ff   <= pend_slot_in;
      pend_status_ff <= pend_status_in;
   end

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for slot_table_with_expiry_top: directed table, then random traffic.
// Depends on stt_pkg and the block's RTL; results are predicted from a shadow copy of the table.
`timescale 1ns / 1ps

module tb;
   import stt_pkg::*;

   localparam int SLOTS       = 16;
   localparam int ITEM_TARGET = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [15:0] req_owner_id;
   logic [15:0] req_lifetime;
   logic [3:0]  req_slot_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_slot_number;
   logic [2:0]  rsp_status;
   logic        rsp_last_result;

   slot_table_with_expiry_top #(.SLOT_COUNT(SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_owner_id    (req_owner_id),
      .req_lifetime    (req_lifetime),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_number (rsp_slot_number),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result)
   );

   // shadow copy of the slot table
   logic [15:0] shadow_owner [SLOTS];
   logic [15:0] shadow_life  [SLOTS];
   rsp_type     pending_results [$];

   int  items_sent;
   int  action_sent [4];
   int  results_seen;
   int  status_seen [8];
   int  mismatch_count;
   int  cycle_count;
   bit  steady;
   bit  long_hold_done;

   typedef struct packed {
      action_type  act;
      logic [15:0] owner;
      logic [15:0] life;
      logic [3:0]  sidx;
      bit          typed;
      logic [3:0]  exp_slot;
      status_type  exp_status;
   } directed_row;

   // typed rows carry their single expected result; the rest go through the predictor
   localparam directed_row SCRIPT [26] = '{
      '{ACT_TICK,      16'h0000, 16'h0000, 4'd0,  1'b1, 4'd0,  ST_NONE},
      '{ACT_REM_SLOT,  16'h0000, 16'h0000, 4'd15, 1'b1, 4'd0,  ST_NOT_FOUND},
      '{ACT_ADD,       16'hffff, 16'h0005, 4'd0,  1'b1, 4'd0,  ST_NOT_FOUND},
      '{ACT_ADD,       16'h0000, 16'h0000, 4'd0,  1'b1, 4'd0,  ST_DONE},
      '{ACT_ADD,       16'hfffe, 16'hffff, 4'd0,  1'b1, 4'd1,  ST_DONE},
      '{ACT_ADD,       16'h1234, 16'h0002, 4'd0,  1'b1, 4'd2,  ST_DONE},
      '{ACT_ADD,       16'h8000, 16'h0001, 4'd0,  1'b1, 4'd3,  ST_DONE},
      '{ACT_ADD,       16'h4000, 16'h0001, 4'd0,  1'b1, 4'd4,  ST_DONE},
      '{ACT_ADD,       16'h1234, 16'h0001, 4'd0,  1'b1, 4'd5,  ST_DONE},
      '{ACT_ADD,       16'h2000, 16'h0001, 4'd0,  1'b1, 4'd6,  ST_DONE},
      '{ACT_ADD,       16'h1000, 16'h0001, 4'd0,  1'b1, 4'd7,  ST_DONE},
      '{ACT_ADD,       16'h0800, 16'h0001, 4'd0,  1'b1, 4'd8,  ST_DONE},
      '{ACT_ADD,       16'h0400, 16'h0001, 4'd0,  1'b1, 4'd9,  ST_DONE},
      '{ACT_ADD,       16'h0200, 16'h0001, 4'd0,  1'b1, 4'd10, ST_DONE},
      '{ACT_ADD,       16'h0100, 16'h0001, 4'd0,  1'b1, 4'd11, ST_DONE},
      '{ACT_ADD,       16'h00ff, 16'h0001, 4'd0,  1'b1, 4'd12, ST_DONE},
      '{ACT_ADD,       16'h7fff, 16'h0001, 4'd0,  1'b1, 4'd13, ST_DONE},
      '{ACT_ADD,       16'h5555, 16'h0001, 4'd0,  1'b1, 4'd14, ST_DONE},
      '{ACT_ADD,       16'haaaa, 16'h0001, 4'd0,  1'b1, 4'd15, ST_DONE},
      '{ACT_ADD,       16'h0001, 16'h0001, 4'd0,  1'b1, 4'd0,  ST_FULL},
      '{ACT_REM_OWNER, 16'hffff, 16'h0000, 4'd0,  1'b1, 4'd0,  ST_NOT_FOUND},
      '{ACT_REM_OWNER, 16'h1234, 16'h0000, 4'd0,  1'b1, 4'd2,  ST_DONE},
      '{ACT_TICK,      16'h0000, 16'h0000, 4'd0,  1'b0, 4'd0,  ST_DONE},
      '{ACT_REM_SLOT,  16'h0000, 16'h0000, 4'd3,  1'b1, 4'd0,  ST_NOT_FOUND},
      '{ACT_REM_OWNER, 16'h0000, 16'h0000, 4'd0,  1'b1, 4'd0,  ST_DONE},
      '{ACT_REM_SLOT,  16'h0000, 16'h0000, 4'd1,  1'b1, 4'd1,  ST_DONE}
   };

   function automatic rsp_type make_rsp(input logic [3:0] slot, input status_type st,
                                        input logic last);
      rsp_type r;
      r.slot_number = slot;
      r.status      = st;
      r.last_result = last;
      return r;
   endfunction

   // update the shadow table and queue the results this transaction must produce
   task automatic apply_table_request(input action_type act, input logic [15:0] owner,
                                      input logic [15:0] life, input logic [3:0] sidx);
      int      i;
      int      n;
      bit      hit;
      rsp_type r;
      rsp_type held;
      n   = 0;
      hit = 1'b0;
      r   = make_rsp(4'd0, ST_NOT_FOUND, 1'b1);
      case (act)
         ACT_ADD: begin
            if (owner != FREE_OWNER) begin
               r.status = ST_FULL;
               for (i = 0; i < SLOTS; i++)
                  if (!hit && shadow_owner[i] == FREE_OWNER) begin
                     hit             = 1'b1;
                     shadow_owner[i] = owner;
                     shadow_life[i]  = life;
                     r               = make_rsp(i[3:0], ST_DONE, 1'b1);
                  end
            end
            pending_results.push_back(r);
         end
         ACT_TICK: begin
            // hold each expiry back one step so the last one can be marked
            for (i = 0; i < SLOTS; i++)
               if (shadow_owner[i] != FREE_OWNER) begin
                  shadow_life[i] = shadow_life[i] - 16'd1;
                  if (shadow_life[i] == 16'd0) begin
                     shadow_owner[i] = FREE_OWNER;
                     if (n < MAX_RESULTS) begin
                        if (n > 0) pending_results.push_back(held);
                        held = make_rsp(i[3:0], ST_EXPIRED, 1'b0);
                        n++;
                     end
                  end
               end
            if (n == 0) begin
               pending_results.push_back(make_rsp(4'd0, ST_NONE, 1'b1));
            end else begin
               held.last_result = 1'b1;
               pending_results.push_back(held);
            end
         end
         ACT_REM_OWNER: begin
            if (owner != FREE_OWNER)
               for (i = 0; i < SLOTS; i++)
                  if (!hit && shadow_owner[i] == owner) begin
                     hit             = 1'b1;
                     shadow_owner[i] = FREE_OWNER;
                     r               = make_rsp(i[3:0], ST_DONE, 1'b1);
                  end
            pending_results.push_back(r);
         end
         default: begin
            if (int'(sidx) < SLOTS && shadow_owner[sidx] != FREE_OWNER) begin
               shadow_owner[sidx] = FREE_OWNER;
               r = make_rsp(sidx, ST_DONE, 1'b1);
            end
            pending_results.push_back(r);
         end
      endcase
   endtask

   task automatic send_request(input action_type act, input logic [15:0] owner,
                               input logic [15:0] life, input logic [3:0] sidx,
                               input bit typed = 1'b0, input logic [3:0] exp_slot = 4'd0,
                               input status_type exp_status = ST_DONE);
      int gap;
      int prior_count;
      if (!steady && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_owner_id   <= owner;
      req_lifetime   <= life;
      req_slot_index <= sidx;
      do @(posedge clock); while (req_stall);
      prior_count = pending_results.size();
      apply_table_request(act, owner, life, sidx);
      if (typed) begin
         while (pending_results.size() > prior_count) void'(pending_results.pop_back());
         pending_results.push_back(make_rsp(exp_slot, exp_status, 1'b1));
      end
      items_sent++;
      action_sent[act]++;
   endtask

   function automatic logic [15:0] pick_owner();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 16'($urandom_range(0, 5));
      if (p < 95) return 16'($urandom_range(0, 16'hfffe));
      return FREE_OWNER;
   endfunction

   // mostly an owner that is actually in the table, so removals hit
   function automatic logic [15:0] pick_victim_owner();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      if (shadow_owner[s] != FREE_OWNER && $urandom_range(0, 9) < 7) return shadow_owner[s];
      return pick_owner();
   endfunction

   function automatic logic [15:0] pick_life();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 16'($urandom_range(1, 4));
      if (p < 75) return 16'h0000;
      if (p < 80) return 16'hffff;
      return 16'($urandom);
   endfunction

   // empty the table, overfill it with short lifetimes, then tick it dry
   task automatic fill_and_flush();
      int i;
      bit uniform;
      uniform = 1'($urandom_range(0, 1));
      for (i = 0; i < SLOTS; i++)
         if (shadow_owner[i] != FREE_OWNER)
            send_request(ACT_REM_SLOT, 16'($urandom), 16'($urandom), i[3:0]);
      repeat (SLOTS + 1)
         send_request(ACT_ADD, 16'($urandom_range(0, 16'hfffe)),
                      uniform ? 16'd1 : 16'($urandom_range(1, 2)), 4'($urandom));
      repeat (2) send_request(ACT_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** slot_table_with_expiry_top: FAILED **");
      $finish;
   end

   // result side: checks every accepted transaction, stalls in random bursts
   initial begin
      int hold;
      bit calm;
      rsp_type want;
      hold = 0;
      calm = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            status_seen[rsp_status]++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: slot %0d status %0d last %0b",
                           rsp_slot_number, rsp_status, rsp_last_result);
            end else begin
               want = pending_results.pop_front();
               if (rsp_slot_number !== want.slot_number || rsp_status !== want.status ||
                   rsp_last_result !== want.last_result) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                              results_seen, want.slot_number, want.status, want.last_result,
                              rsp_slot_number, rsp_status, rsp_last_result);
               end
            end
         end
         if ($urandom_range(0, 99) == 0) calm = !calm;
         // one long hold-off so the block backs up and stalls its input
         if (!long_hold_done && results_seen == 80) begin
            long_hold_done = 1'b1;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (!reset && !steady && !calm && $urandom_range(0, 6) == 0) begin
            hold = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int  i;
      int  pick;
      bit  paused;
      paused         = 1'b0;
      steady         = 1'b0;
      long_hold_done = 1'b0;
      items_sent     = 0;
      results_seen   = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      for (i = 0; i < 4; i++) action_sent[i] = 0;
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      for (i = 0; i < SLOTS; i++) begin
         shadow_owner[i] = FREE_OWNER;
         shadow_life[i]  = 16'd0;
      end
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_ADD;
      req_owner_id   <= 16'd0;
      req_lifetime   <= 16'd0;
      req_slot_index <= 4'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(SCRIPT); i++)
         send_request(SCRIPT[i].act, SCRIPT[i].owner, SCRIPT[i].life, SCRIPT[i].sidx,
                      SCRIPT[i].typed, SCRIPT[i].exp_slot, SCRIPT[i].exp_status);

      while (items_sent < ITEM_TARGET) begin
         if (!paused && items_sent >= 150) begin
            // drain completely before carrying on
            paused = 1'b1;
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         steady = (items_sent >= ITEM_TARGET - 50);
         pick   = $urandom_range(0, 99);
         if (!steady && $urandom_range(0, 29) == 0)
            fill_and_flush();
         else if (pick < 35)
            send_request(ACT_ADD, pick_owner(), pick_life(), 4'($urandom));
         else if (pick < 65)
            send_request(ACT_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
         else if (pick < 80)
            send_request(ACT_REM_OWNER, pick_victim_owner(), 16'($urandom), 4'($urandom));
         else if (pick < 95)
            send_request(ACT_REM_SLOT, 16'($urandom), 16'($urandom),
                         4'($urandom_range(0, SLOTS - 1)));
         else
            send_request(action_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                         4'($urandom));
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);

      $display("Ran %0d requests: %0d adds, %0d ticks, %0d owner removals, %0d slot removals.",
               items_sent, action_sent[ACT_ADD], action_sent[ACT_TICK],
               action_sent[ACT_REM_OWNER], action_sent[ACT_REM_SLOT]);
      $display("Checked %0d results: %0d expired, %0d full, %0d not found, %0d idle ticks.",
               results_seen, status_seen[ST_EXPIRED], status_seen[ST_FULL],
               status_seen[ST_NOT_FOUND], status_seen[ST_NONE]);
      if (mismatch_count == 0)
         $display("** slot_table_with_expiry_top: PASSED **");
      else
         $display("** slot_table_with_expiry_top: FAILED **");
      $finish;
   end

endmodule

>>> slot_table_with_expiry_top.f
sv/stt_pkg.sv
sv/stt_mem.sv
sv/stt_ctrl.sv
sv/slot_table_with_expiry_top.sv
sim/tb.sv
